### hw/rtl/lzwe_pkg.sv
package lzwe_pkg;

    localparam int FIRST_CODE_DEF = 256;
    localparam int CODE_LIMIT_DEF = 4096;
    localparam int HASH_SLOTS_DEF = 8192;
    localparam int OUT_CODE_W     = 12;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HMUL,
        ST_HXOR,
        ST_HMOD,
        ST_HDISP,
        ST_FCHK,
        ST_EMITM,
        ST_EJ,
        ST_ECHK,
        ST_EK,
        ST_EMOVE,
        ST_ICHK,
        ST_EMITL
    } t_state;

    typedef enum logic [1:0] {
        PH_FIND,
        PH_INS,
        PH_EVK
    } t_phase;

endpackage

### hw/rtl/lzwe_in_if.sv
interface lzwe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

### hw/rtl/lzwe_out_if.sv
interface lzwe_out_if
    import lzwe_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [OUT_CODE_W-1:0] code;
    logic                  last_code;

    modport source (output valid, output code, output last_code, input ready);
    modport sink   (input valid, input code, input last_code, output ready);
endinterface

### hw/rtl/lzw_byte_encoder_wrapping_dict.sv
// LZW byte encoder with a hashed dictionary of (prefix, byte) -> code held in one
// synchronous RAM, plus a code -> slot RAM used to evict the entry of a reused code.
// A byte that extends the prefix needs the hash and a probe run in the dictionary. A
// miss emits the prefix, which waits while the output register is still full, then
// hashes again to insert. When the reused code still has an entry, eviction clears
// it and moves back each entry that follows in the probe run if its hash allows.
// A non-power-of-two HASH_SLOTS adds a modular reduction to each hash.
// After reset and after every end of input the dictionary RAM is cleared; no byte
// is taken meanwhile. Results leave through an output register, so the next byte
// is taken while the last code still waits.
module lzw_byte_encoder_wrapping_dict
    import lzwe_pkg::*;
#(
    parameter int FIRST_CODE = FIRST_CODE_DEF,
    parameter int CODE_LIMIT = CODE_LIMIT_DEF,
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lzwe_in_if.sink           i_in,
    lzwe_out_if.source        o_out
);
    localparam int CW    = $clog2(CODE_LIMIT);
    localparam int SB    = $clog2(HASH_SLOTS);
    localparam int EW    = 2 * CW + 9;
    localparam int KMAX  = 32 - SB;
    localparam int KW    = $clog2(KMAX + 1);
    localparam bit HS_P2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CW-1:0] r_prefix, n_prefix, r_next, n_next;
    logic          r_pvalid, n_pvalid;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    logic [23:0]   r_hkey, n_hkey;
    logic [31:0]   r_h, n_h;
    logic [KW-1:0] r_hk, n_hk;
    logic [SB-1:0] r_hs, n_hs, r_s, n_s, r_j, n_j, r_k, n_k, r_clr, n_clr;
    logic [SB:0]   r_n, n_n;
    logic [EW-1:0] r_ent, n_ent;
    logic          r_ovalid, n_ovalid;
    logic [OUT_CODE_W-1:0] r_ocode, n_ocode;
    logic          r_olast, n_olast;

    logic          d_we;
    logic [SB-1:0] d_wa, d_ra;
    logic [EW-1:0] d_wd, d_rd;
    logic          s_we;
    logic [CW-1:0] s_wa, s_ra;
    logic [SB-1:0] s_wd, s_rd;

    logic          emit_ok, d_v, stays;
    logic [CW-1:0] d_pre, d_code;
    logic [7:0]    d_byte;
    logic [31:0]   hx;
    logic [32:0]   sub;

    function automatic logic [SB-1:0] step(input logic [SB-1:0] s);
        return (s == SB'(HASH_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    lzwe_ram #(.W(EW), .D(HASH_SLOTS)) u_dict (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_wa), .i_wdata(d_wd),
        .i_raddr(d_ra), .o_rdata(d_rd)
    );

    lzwe_ram #(.W(SB), .D(CODE_LIMIT)) u_slot (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );

    assign d_v    = d_rd[EW-1];
    assign d_pre  = d_rd[EW-2 -: CW];
    assign d_byte = d_rd[CW+7:CW];
    assign d_code = d_rd[CW-1:0];
    assign emit_ok = !r_ovalid || o_out.ready;
    assign hx  = r_h ^ (r_h >> 15);
    assign sub = 33'(HASH_SLOTS) << r_hk;
    assign stays = (r_j <= r_k) ? (r_hs > r_j && r_hs <= r_k)
                                : (r_hs > r_j || r_hs <= r_k);

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.code      = r_ocode;
    assign o_out.last_code = r_olast;

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_prefix = r_prefix;
        n_next = r_next;    n_pvalid = r_pvalid; n_byte = r_byte;
        n_last = r_last;    n_hkey = r_hkey;    n_h = r_h;
        n_hk = r_hk;        n_hs = r_hs;        n_s = r_s;
        n_j = r_j;          n_k = r_k;          n_clr = r_clr;
        n_n = r_n;          n_ent = r_ent;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ocode = r_ocode;  n_olast = r_olast;
        d_we = 1'b0; d_wa = r_s; d_wd = '0; d_ra = r_s;
        s_we = 1'b0; s_wa = r_next; s_wd = r_s; s_ra = r_next;

        unique case (r_state)
            ST_CLEAR: begin
                d_we = 1'b1;
                d_wa = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == SB'(HASH_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_byte = i_in.data_byte;
                    n_last = i_in.end_of_input;
                    if (!r_pvalid) begin
                        n_prefix = CW'(i_in.data_byte);
                        n_pvalid = 1'b1;
                        n_state = i_in.end_of_input ? ST_EMITL : ST_IDLE;
                    end else begin
                        n_hkey  = {16'(r_prefix), i_in.data_byte};
                        n_phase = PH_FIND;
                        n_state = ST_HMUL;
                    end
                end
            end
            ST_HMUL: begin
                n_h = 32'({8'd0, r_hkey} * HASH_MULT);
                n_state = ST_HXOR;
            end
            ST_HXOR: begin
                if (HS_P2) begin
                    n_hs = hx[SB-1:0];
                    n_state = ST_HDISP;
                end else begin
                    n_h = hx;
                    n_hk = KW'(KMAX);
                    n_state = ST_HMOD;
                end
            end
            ST_HMOD: begin
                if ({1'b0, r_h} >= sub) begin
                    n_h = 32'({1'b0, r_h} - sub);
                end
                if (r_hk == '0) begin
                    n_hs = n_h[SB-1:0];
                    n_state = ST_HDISP;
                end else begin
                    n_hk = r_hk - 1'b1;
                end
            end
            ST_HDISP: begin
                unique case (r_phase)
                    PH_FIND, PH_INS: begin
                        n_s = r_hs;
                        n_n = '0;
                        d_ra = r_hs;
                        n_state = (r_phase == PH_FIND) ? ST_FCHK : ST_ICHK;
                    end
                    PH_EVK: begin
                        if (!stays) begin
                            d_we = 1'b1;
                            d_wa = r_j;
                            d_wd = r_ent;
                            s_we = 1'b1;
                            s_wa = r_ent[CW-1:0];
                            s_wd = r_j;
                            n_state = ST_EMOVE;
                        end else begin
                            n_k = step(r_k);
                            d_ra = step(r_k);
                            n_state = ST_EK;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FCHK: begin
                if (!d_v) begin
                    n_state = ST_EMITM;
                end else if (d_pre == r_prefix && d_byte == r_byte) begin
                    n_prefix = d_code;
                    n_state = r_last ? ST_EMITL : ST_IDLE;
                end else if (r_n == (SB+1)'(HASH_SLOTS - 1)) begin
                    n_state = ST_EMITM;
                end else begin
                    n_n = r_n + 1'b1;
                    n_s = step(r_s);
                    d_ra = step(r_s);
                end
            end
            ST_EMITM: begin
                if (emit_ok) begin
                    n_ovalid = 1'b1;
                    n_ocode = OUT_CODE_W'(r_prefix);
                    n_olast = 1'b0;
                    s_ra = r_next;
                    n_state = ST_EJ;
                end
            end
            ST_EJ: begin
                n_j = s_rd;
                d_ra = s_rd;
                n_state = ST_ECHK;
            end
            ST_ECHK: begin
                if (d_v && d_code == r_next) begin
                    d_we = 1'b1;
                    d_wa = r_j;
                    n_k = step(r_j);
                    d_ra = step(r_j);
                    n_state = ST_EK;
                end else begin
                    n_hkey = {16'(r_prefix), r_byte};
                    n_phase = PH_INS;
                    n_state = ST_HMUL;
                end
            end
            ST_EK: begin
                if (!d_v) begin
                    n_hkey = {16'(r_prefix), r_byte};
                    n_phase = PH_INS;
                end else begin
                    n_ent = d_rd;
                    n_hkey = {16'(d_pre), d_byte};
                    n_phase = PH_EVK;
                end
                n_state = ST_HMUL;
            end
            ST_EMOVE: begin
                d_we = 1'b1;
                d_wa = r_k;
                n_j = r_k;
                n_k = step(r_k);
                d_ra = step(r_k);
                n_state = ST_EK;
            end
            ST_ICHK: begin
                if (!d_v || r_n == (SB+1)'(HASH_SLOTS - 1)) begin
                    if (!d_v) begin
                        d_we = 1'b1;
                        d_wa = r_s;
                        d_wd = {1'b1, r_prefix, r_byte, r_next};
                        s_we = 1'b1;
                        s_wa = r_next;
                        s_wd = r_s;
                    end
                    n_next = (r_next == CW'(CODE_LIMIT - 1)) ? CW'(FIRST_CODE)
                                                              : r_next + 1'b1;
                    n_prefix = CW'(r_byte);
                    n_state = r_last ? ST_EMITL : ST_IDLE;
                end else begin
                    n_n = r_n + 1'b1;
                    n_s = step(r_s);
                    d_ra = step(r_s);
                end
            end
            ST_EMITL: begin
                if (emit_ok) begin
                    n_ovalid = 1'b1;
                    n_ocode = OUT_CODE_W'(r_prefix);
                    n_olast = 1'b1;
                    n_prefix = '0;
                    n_pvalid = 1'b0;
                    n_next = CW'(FIRST_CODE);
                    n_clr = '0;
                    n_state = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_pvalid <= 1'b0;
            r_prefix <= '0;
            r_next   <= CW'(FIRST_CODE);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pvalid <= n_pvalid;
            r_prefix <= n_prefix;
            r_next   <= n_next;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_hkey  <= n_hkey;
        r_h     <= n_h;
        r_hk    <= n_hk;
        r_hs    <= n_hs;
        r_s     <= n_s;
        r_j     <= n_j;
        r_k     <= n_k;
        r_n     <= n_n;
        r_ent   <= n_ent;
        r_ocode <= n_ocode;
        r_olast <= n_olast;
    end
endmodule

### hw/rtl/lzwe_ram.sv
module lzwe_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/lzwe_checker.sv
module lzwe_checker
    import lzwe_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_in_last,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [OUT_CODE_W-1:0] i_out_code,
    input logic                  i_out_last
);
    logic r_pending;
    logic in_beat, out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (in_beat && i_in_last) begin
            r_pending <= 1'b1;
        end else if (out_beat && i_out_last) begin
            r_pending <= 1'b0;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ports not quiet after reset");

    a_no_input_before_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> !r_pending)
        else $error("input beat taken before final code delivered");

    a_last_only_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && i_out_last |-> r_pending)
        else $error("final code without end of input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code)
            && $stable(i_out_last))
        else $error("stalled output beat changed");
endmodule

bind lzw_byte_encoder_wrapping_dict lzwe_checker u_lzwe_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_in_last(i_in.end_of_input),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_code(o_out.code),
    .i_out_last(o_out.last_code)
);
